FILE: design/rmts_pkg.sv
// Shared types and constants for the rate-monotonic tick scheduler.
package rmts_pkg;

	// Number of task register slots in the configuration map.
	localparam int SLOTS = 4;
	localparam int CFG_W = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef logic [1:0]        task_idx_t;
	typedef logic [2:0]        choice_t;
	typedef logic [2:0]        reg_idx_t;
	typedef logic [CFG_W-1:0]  cfg_word_t;

	// Choice codes: 0..3 name a task.
	localparam choice_t CHOICE_IDLE  = 3'd4;
	localparam choice_t CHOICE_UNSET = 3'd7;

	// Register map: bursts first, then periods.
	localparam reg_idx_t REG_BURST_BASE  = 3'd0;
	localparam reg_idx_t REG_PERIOD_BASE = 3'd4;

endpackage

FILE: design/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler: per-tick release, priority pick and work accounting.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+------------------------------------------
//  tick in  | in_valid / in_stall               | restart
//  result   | out_valid / out_stall             | running_task, cpu_idle, choice_changed,
//           |                                   | tick_time
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
//  One tick per clock cycle. A tick is handled in the cycle of its transfer: the release
//  check, the four-way period compare and the counter updates form one combinational pass
//  that loads the result register. The result register is the only buffer, so a stalled
//  result holds off the next tick (in_stall follows a full, stalled result register); a
//  result taken in the same cycle frees the slot for the next tick at once.
//  Reset clears time, phases, remaining work and the result valid, sets bursts to 0 and
//  periods to 1, and marks the previous choice unset so the first tick reports a change.
module rate_monotonic_tick_scheduler #(
	parameter int TASKS      = 4,
	parameter int COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// tick channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       restart,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output rmts_pkg::task_idx_t        running_task,
	output logic                       cpu_idle,
	output logic                       choice_changed,
	output logic [31:0]                tick_time,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rmts_pkg::ADDR_W-1:0] paddr,
	input  logic [rmts_pkg::DATA_W-1:0] pwdata,
	output logic [rmts_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import rmts_pkg::*;

	// Compare width wide enough for both a phase count and a 16-bit register.
	localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

	typedef logic [COUNT_BITS-1:0] cnt_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	cfg_word_t burst_q  [SLOTS];
	cfg_word_t period_q [SLOTS];

	reg_idx_t  cfg_idx;
	logic      cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				burst_q[i]  <= '0;
				period_q[i] <= cfg_word_t'(1);
			end
		end else if (cfg_wr) begin
			// Bursts sit below the period base, periods at and above it.
			if (cfg_idx < REG_PERIOD_BASE) begin
				burst_q[2'(cfg_idx - REG_BURST_BASE)] <= pwdata[CFG_W-1:0];
			end else begin
				period_q[2'(cfg_idx - REG_PERIOD_BASE)] <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (cfg_idx < REG_PERIOD_BASE) begin
			prdata = DATA_W'(burst_q[2'(cfg_idx - REG_BURST_BASE)]);
		end else begin
			prdata = DATA_W'(period_q[2'(cfg_idx - REG_PERIOD_BASE)]);
		end
	end

	// ------------------------------------------------------------------
	// Scheduler state
	// ------------------------------------------------------------------
	logic [31:0] elapsed_q;
	cnt_t        phase_q [TASKS];
	cnt_t        work_q  [TASKS];
	choice_t     prev_choice_q;

	// Result register
	logic        out_valid_q;
	task_idx_t   running_task_q;
	logic        cpu_idle_q;
	logic        choice_changed_q;
	logic [31:0] tick_time_q;

	logic        in_xfer;
	logic        out_xfer;

	// Hold the tick side only while a finished result is stalled.
	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	// ------------------------------------------------------------------
	// One-pass tick evaluation
	// ------------------------------------------------------------------
	logic [31:0]      now;
	cnt_t             phase_cur [TASKS];
	cnt_t             work_rel  [TASKS];
	cnt_t             phase_nxt [TASKS];
	cnt_t             work_nxt  [TASKS];
	cfg_word_t        eff_period [TASKS];
	logic [CMP_W-1:0] burst_ext;
	cnt_t             phase_inc;
	logic             sel_found;
	task_idx_t        sel_idx;
	cfg_word_t        best_period;
	choice_t          choice;

	always_comb begin
		// Restart clears time, phases and work before this tick is handled.
		now = restart ? '0 : elapsed_q;

		for (int i = 0; i < TASKS; i++) begin
			phase_cur[i]  = restart ? '0 : phase_q[i];
			eff_period[i] = (period_q[i] == '0) ? cfg_word_t'(1) : period_q[i];

			// Release: reload work, saturating the burst to the counter range.
			burst_ext = CMP_W'(burst_q[i]);
			if (phase_cur[i] == '0) begin
				work_rel[i] = (burst_ext > CNT_MAX) ? cnt_t'(CNT_MAX)
				                                    : burst_ext[COUNT_BITS-1:0];
			end else begin
				work_rel[i] = restart ? '0 : work_q[i];
			end

			// Advance the phase, wrapping at the period.
			phase_inc = phase_cur[i] + cnt_t'(1);
			phase_nxt[i] = (CMP_W'(phase_inc) >= CMP_W'(eff_period[i])) ? '0 : phase_inc;
		end

		// Smallest period among runnable tasks; ties keep the lower index.
		sel_found   = 1'b0;
		sel_idx     = '0;
		best_period = '0;
		for (int i = 0; i < TASKS; i++) begin
			if (work_rel[i] != '0 && (!sel_found || eff_period[i] < best_period)) begin
				sel_found   = 1'b1;
				sel_idx     = task_idx_t'(i);
				best_period = eff_period[i];
			end
		end

		for (int i = 0; i < TASKS; i++) begin
			work_nxt[i] = (sel_found && sel_idx == task_idx_t'(i)) ? work_rel[i] - cnt_t'(1)
			                                                       : work_rel[i];
		end

		choice = sel_found ? {1'b0, sel_idx} : CHOICE_IDLE;
	end

	// ------------------------------------------------------------------
	// State and result registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q     <= '0;
			prev_choice_q <= CHOICE_UNSET;
			for (int i = 0; i < TASKS; i++) begin
				phase_q[i] <= '0;
				work_q[i]  <= '0;
			end
		end else if (in_xfer) begin
			elapsed_q     <= now + 32'd1;
			prev_choice_q <= choice;
			for (int i = 0; i < TASKS; i++) begin
				phase_q[i] <= phase_nxt[i];
				work_q[i]  <= work_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload loads on every tick transfer; it never changes while stalled.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			running_task_q   <= sel_found ? sel_idx : '0;
			cpu_idle_q       <= !sel_found;
			choice_changed_q <= (choice != prev_choice_q);
			tick_time_q      <= now;
		end
	end

	assign out_valid      = out_valid_q;
	assign running_task   = running_task_q;
	assign cpu_idle       = cpu_idle_q;
	assign choice_changed = choice_changed_q;
	assign tick_time      = tick_time_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("tick side stalled with an empty result register");

	a_xfer_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> out_valid)
		else $error("tick transfer left no result");

	a_restart_zero_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && restart |=> tick_time == 32'd0)
		else $error("restart tick did not report time zero");

	a_time_advances: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !restart && out_valid_q |=> tick_time == $past(tick_time) + 32'd1)
		else $error("tick time did not advance by one");

	a_idle_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cpu_idle |-> running_task == '0)
		else $error("idle result names a task");

endmodule
